// ===== rtl/assert_macros.svh =====
// Assertion macros used by the table top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define UAT_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define UAT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define UAT_ASSERT(label, clk, rstn, prop)
`define UAT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/uat_pkg.sv =====
// Types and codes of the unordered array table.
package uat_pkg;
  localparam int DataW = 32;

  localparam logic [2:0] ModeInsert    = 3'd0;
  localparam logic [2:0] ModeRemove    = 3'd1;
  localparam logic [2:0] ModeSearch    = 3'd2;
  localparam logic [2:0] ModeFindAll   = 3'd3;
  localparam logic [2:0] ModeRemoveAll = 3'd4;
  localparam logic [2:0] ModeDedupe    = 3'd5;

  localparam logic [1:0] StatOk       = 2'd0;
  localparam logic [1:0] StatFull     = 2'd1;
  localparam logic [1:0] StatEmpty    = 2'd2;
  localparam logic [1:0] StatNotFound = 2'd3;

  localparam int ResultLimit = 16;

  typedef struct packed {
    logic [2:0]        mode;
    logic signed [31:0] operand;
  } uat_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] match_index;
    logic [4:0] match_count;
    logic [4:0] occupancy;
    logic       last_of_run;
  } uat_res_t;

  typedef struct packed {
    logic shift;
    logic load;
  } uat_cell_ctl_t;
endpackage

// ===== rtl/unordered_array_table.sv =====
// Unordered array table top level: command sequencer over a row of entry cells.
// Results come as one-cycle strobes on res_valid_o and cannot be held off.
// Insert, unused modes and remove-first on an empty table answer in the cycle
// after start. Remove first, search, find all, remove all and dedupe scan the
// row through its head cell, one entry per cycle; remove first, when it finds a
// match, then passes a fix state before it answers. Find all puts out each
// match during the scan, once the next match is found, or at its end.
module unordered_array_table import uat_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  uat_cmd_t cmd_i,
  output logic     res_valid_o,
  output uat_res_t res_o,
  input  logic     cfg_valid_i,
  output logic     cfg_ready_o,
  input  logic [4:0] cfg_data_i
);
`include "assert_macros.svh"
  localparam int N  = MAX_ENTRIES;
  localparam int CW = $clog2(N + 1);
  localparam int IW = $clog2(N);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StFix  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [4:0]       cap_q;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    s_q, s_d, w_q, w_d, n_q, n_d;
  logic [2:0]       mode_q, mode_d;
  logic [DataW-1:0] op_q, op_d;
  logic             found_q, found_d;
  logic [IW-1:0]    fi_q, fi_d;
  logic             pend_q, pend_d;
  logic [CW-1:0]    pidx_q, pidx_d, pcnt_q, pcnt_d;
  logic             rv_q, rv_d;
  uat_res_t         res_q, res_d;

  logic [DataW-1:0] cq [N];
  logic             hit [N];
  uat_cell_ctl_t    ctl [N];
  logic [DataW-1:0] ld  [N];
  logic [DataW-1:0] key, head;
  logic [CW:0]      lo;
  logic             dup, keep, head_eq, full;
  logic [IW-1:0]    ins, last_idx;

  assign head     = cq[0];
  assign head_eq  = (head == op_q);
  assign key      = (mode_q == ModeDedupe) ? head : op_q;
  assign lo       = (CW+1)'(count_q) - (CW+1)'(s_q);
  assign ins      = IW'(count_q - s_q - CW'(1) + w_q);
  assign last_idx = IW'(count_q - CW'(1));
  assign full     = (32'(count_q) >= 32'(cap_q)) || (32'(count_q) >= 32'(N));

  always_comb begin
    dup = 1'b0;
    for (int k = 0; k < N; k++) begin
      if (((CW+1)'(k) >= lo) && ((CW+1)'(k) < lo + (CW+1)'(w_q)) && hit[k]) begin
        dup = 1'b1;
      end
    end
  end

  always_comb begin
    case (mode_q)
      ModeRemoveAll: keep = !head_eq;
      ModeDedupe:    keep = !dup;
      default:       keep = 1'b1;
    endcase
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    localparam int Nx = (k + 1) % N;
    uat_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl[k]),
      .shift_i (cq[Nx]),
      .load_i  (ld[k]),
      .key_i   (key),
      .q_o     (cq[k]),
      .hit_o   (hit[k])
    );
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    s_d     = s_q;
    w_d     = w_q;
    n_d     = n_q;
    mode_d  = mode_q;
    op_d    = op_q;
    found_d = found_q;
    fi_d    = fi_q;
    pend_d  = pend_q;
    pidx_d  = pidx_q;
    pcnt_d  = pcnt_q;
    rv_d    = 1'b0;
    res_d   = res_q;
    for (int k = 0; k < N; k++) begin
      ctl[k] = '0;
      ld[k]  = head;
    end

    unique case (state_q)
      StIdle: begin
        if (start) begin
          mode_d  = cmd_i.mode;
          op_d    = cmd_i.operand;
          s_d     = '0;
          w_d     = '0;
          n_d     = '0;
          found_d = 1'b0;
          pend_d  = 1'b0;
          res_d   = '{status: StatOk, match_index: '0, match_count: '0,
                      occupancy: 5'(count_q), last_of_run: 1'b1};
          unique case (cmd_i.mode) inside
            ModeInsert: begin
              rv_d = 1'b1;
              if (full) begin
                res_d.status = StatFull;
              end else begin
                ctl[IW'(count_q)].load = 1'b1;
                ld[IW'(count_q)]       = cmd_i.operand;
                count_d                = count_q + CW'(1);
                res_d.occupancy        = 5'(count_q + CW'(1));
              end
            end
            ModeRemove: begin
              if (count_q == '0) begin
                rv_d         = 1'b1;
                res_d.status = StatEmpty;
              end else begin
                state_d = StScan;
              end
            end
            ModeSearch, ModeFindAll, ModeRemoveAll, ModeDedupe: begin
              state_d = StScan;
            end
            default: rv_d = 1'b1;
          endcase
        end
      end
      StScan: begin
        if (s_q != count_q) begin
          for (int k = 0; k < N; k++) begin
            ctl[k].shift = 1'b1;
          end
          if (keep) begin
            ctl[ins].load = 1'b1;
            w_d = w_q + CW'(1);
          end
          s_d = s_q + CW'(1);
          if (head_eq && !found_q) begin
            found_d = 1'b1;
            fi_d    = IW'(s_q);
          end
          if (mode_q == ModeFindAll && head_eq && 32'(n_q) < ResultLimit) begin
            n_d    = n_q + CW'(1);
            pend_d = 1'b1;
            pidx_d = s_q;
            pcnt_d = n_q + CW'(1);
            if (pend_q) begin
              rv_d  = 1'b1;
              res_d = '{status: StatOk, match_index: 4'(pidx_q),
                        match_count: 5'(pcnt_q), occupancy: 5'(count_q),
                        last_of_run: 1'b0};
            end
          end
        end else begin
          count_d = w_q;
          state_d = StIdle;
          rv_d    = 1'b1;
          res_d   = '{status: StatOk, match_index: '0, match_count: '0,
                      occupancy: 5'(w_q), last_of_run: 1'b1};
          case (mode_q)
            ModeRemove: begin
              if (found_q) begin
                rv_d    = 1'b0;
                state_d = StFix;
              end else begin
                res_d.status = StatNotFound;
              end
            end
            ModeSearch: begin
              if (found_q) begin
                res_d.match_index = 4'(fi_q);
              end else begin
                res_d.status = StatNotFound;
              end
            end
            ModeFindAll: begin
              if (pend_q) begin
                res_d.match_index = 4'(pidx_q);
                res_d.match_count = 5'(pcnt_q);
              end else begin
                res_d.status = StatNotFound;
              end
            end
            default: res_d.match_count = 5'(count_q - w_q);
          endcase
        end
      end
      StFix: begin
        ctl[fi_q].load = 1'b1;
        ld[fi_q]       = cq[last_idx];
        count_d        = count_q - CW'(1);
        state_d        = StIdle;
        rv_d           = 1'b1;
        res_d = '{status: StatOk, match_index: '0, match_count: 5'd1,
                  occupancy: 5'(count_q - CW'(1)), last_of_run: 1'b1};
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      cap_q   <= 5'd16;
      rv_q    <= 1'b0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
      s_q     <= '0;
      w_q     <= '0;
      n_q     <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rv_q    <= rv_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      s_q     <= s_d;
      w_q     <= w_d;
      n_q     <= n_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    op_q   <= op_d;
    fi_q   <= fi_d;
    pidx_q <= pidx_d;
    pcnt_q <= pcnt_d;
    res_q  <= res_d;
  end

  assign busy        = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  `UAT_ASSERT(a_count_max, clk_i, rst_ni, 32'(count_q) <= N)
  `UAT_ASSERT(a_scan_bound, clk_i, rst_ni, (state_q != StScan) || (s_q <= count_q))
  `UAT_ASSERT(a_keep_bound, clk_i, rst_ni, (state_q != StScan) || (w_q <= s_q))
  `UAT_ASSERT_NEXT(a_insert_answers, clk_i, rst_ni, start && !busy && cmd_i.mode == ModeInsert, res_valid_o)
endmodule

// ===== rtl/uat_cell.sv =====
// One table cell: holds an entry, shifts from its neighbor, compares to a key.
module uat_cell import uat_pkg::*; (
  input  logic             clk_i,
  input  uat_cell_ctl_t    ctl_i,
  input  logic [DataW-1:0] shift_i,
  input  logic [DataW-1:0] load_i,
  input  logic [DataW-1:0] key_i,
  output logic [DataW-1:0] q_o,
  output logic             hit_o
);
  logic [DataW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (ctl_i.load) begin
      data_d = load_i;
    end else if (ctl_i.shift) begin
      data_d = shift_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o   = data_q;
  assign hit_o = (data_q == key_i);
endmodule
